### rtl/sobel_edge_magnitude_macros.svh
// Assertion helpers for the Sobel edge magnitude block.
`ifndef SOBEL_EDGE_MAGNITUDE_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every clock edge outside reset
`define SOBEL_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("sobel assertion failed");

// cond must never be true outside reset
`define SOBEL_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("sobel forbidden condition");

`else

`define SOBEL_ASSERT(label, clk, rst, prop)
`define SOBEL_NEVER(label, clk, rst, cond)

`endif

`endif

### rtl/sobel_pkg.sv
package sobel_pkg;

   localparam int PIX_W          = 8;
   localparam int CFG_W          = 11;
   localparam int CSR_IDX_W      = 1;
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;
   localparam int MIN_DIM        = 3;
   localparam int MAG_MAX        = 255;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QCOUNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int QPTR_W         = $clog2(QUEUE_DEPTH);

   localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LINE_WIDTH   = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // clamped gradient pair of one interior pixel
   typedef struct packed {
      logic [PIX_W-1:0] ax;
      logic [PIX_W-1:0] ay;
      logic             last;
   } grad_type;

   typedef struct packed {
      logic     push;
      grad_type data;
   } grad_push_type;

   typedef struct packed {
      logic     empty;
      grad_type data;
   } grad_head_type;

endpackage

### rtl/sobel_ram.sv
module sobel_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/sobel_front.sv
module sobel_front #(
   parameter int MAX_WIDTH  = sobel_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = sobel_pkg::DEF_MAX_HEIGHT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_push,
   output logic                                   req_full,
   input  logic [sobel_pkg::PIX_W-1:0]            req_intensity,
   input  logic                                   req_start_of_frame,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]         width_eff,
   input  logic [$clog2(MAX_HEIGHT+1)-1:0]        height_eff,
   input  logic [sobel_pkg::QCOUNT_W-1:0]         q_count,
   output sobel_pkg::grad_push_type               q_push
);

   localparam int CW    = $clog2(MAX_WIDTH + 1);
   localparam int RW    = $clog2(MAX_HEIGHT + 1);
   localparam int AW    = $clog2(MAX_WIDTH);
   localparam int PW    = sobel_pkg::PIX_W;
   localparam int SUM_W = PW + 2;
   localparam int DIF_W = PW + 3;

   // position counters
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;

   // stage B: RAM read in flight
   logic          b_valid_ff, b_valid_in;
   logic [PW-1:0] b_pix_ff;
   logic [AW-1:0] b_addr_ff;
   logic          b_interior_ff;
   logic          b_last_ff;

   // bypass of the line store write that lands on the edge of the read
   logic            fwd_hit;
   logic            fwd_ff;
   logic [2*PW-1:0] fwd_data_ff;

   // window: l* older column, c* newer column (top, mid, bottom)
   logic [PW-1:0] l0_ff, l1_ff, l2_ff, c0_ff, c1_ff, c2_ff;

   logic          accept;
   logic [CW-1:0] c_pos, c_next;
   logic [RW-1:0] r_pos, r_next;
   logic          a_interior, a_last;

   logic [PW-1:0]      top, mid;
   logic [2*PW-1:0]    rd_data;
   logic [SUM_W-1:0]   gx_pos, gx_neg, gy_pos, gy_neg;
   logic signed [DIF_W-1:0] gx, gy;
   logic [sobel_pkg::QCOUNT_W:0] pending;

   function automatic logic [PW-1:0] clamp_byte(input logic signed [DIF_W-1:0] v);
      logic [PW-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > DIF_W'(sobel_pkg::MAG_MAX)) begin
         r = PW'(sobel_pkg::MAG_MAX);
      end else begin
         r = v[PW-1:0];
      end
      return r;
   endfunction

   // room for this transaction and the one in stage B
   assign pending  = {1'b0, q_count} + {{sobel_pkg::QCOUNT_W{1'b0}}, b_valid_ff};
   assign req_full = pending >= (sobel_pkg::QCOUNT_W + 1)'(sobel_pkg::QUEUE_DEPTH);
   assign accept   = req_push && !req_full;

   always_comb begin
      c_pos = req_start_of_frame ? '0 : col_ff;
      r_pos = req_start_of_frame ? '0 : row_ff;
      // width or height lowered since the last pixel
      if (c_pos >= width_eff) begin
         c_pos = '0;
         r_pos = r_pos + RW'(1);
      end
      if (r_pos >= height_eff) begin
         r_pos = '0;
      end
      a_interior = (c_pos >= CW'(2)) && (r_pos >= RW'(2));
      a_last     = (r_pos == height_eff - RW'(1)) && (c_pos == width_eff - CW'(1));
      c_next = c_pos + CW'(1);
      r_next = r_pos;
      if (c_next >= width_eff) begin
         c_next = '0;
         r_next = r_pos + RW'(1);
         if (r_next >= height_eff) begin
            r_next = '0;
         end
      end
   end

   assign col_in     = accept ? c_next : col_ff;
   assign row_in     = accept ? r_next : row_ff;
   assign b_valid_in = accept;

   // a restart on column 0 right after a column 0 pixel reads the entry being written
   assign fwd_hit = b_valid_ff && (b_addr_ff == c_pos[AW-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         b_valid_ff <= 1'b0;
         l0_ff      <= '0;
         l1_ff      <= '0;
         l2_ff      <= '0;
         c0_ff      <= '0;
         c1_ff      <= '0;
         c2_ff      <= '0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         b_valid_ff <= b_valid_in;
         if (b_valid_ff) begin
            l0_ff <= c0_ff;
            l1_ff <= c1_ff;
            l2_ff <= c2_ff;
            c0_ff <= top;
            c1_ff <= mid;
            c2_ff <= b_pix_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_pix_ff      <= req_intensity;
         b_addr_ff     <= c_pos[AW-1:0];
         b_interior_ff <= a_interior;
         b_last_ff     <= a_last;
         fwd_ff        <= fwd_hit;
         fwd_data_ff   <= {mid, b_pix_ff};
      end
   end

   // two previous lines packed per column: {line row-2, line row-1}
   sobel_ram #(
      .WIDTH (2 * PW),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (b_valid_ff),
      .wr_addr (b_addr_ff),
      .wr_data ({mid, b_pix_ff}),
      .rd_en   (accept),
      .rd_addr (c_pos[AW-1:0]),
      .rd_data (rd_data)
   );

   assign top = fwd_ff ? fwd_data_ff[2*PW-1:PW] : rd_data[2*PW-1:PW];
   assign mid = fwd_ff ? fwd_data_ff[PW-1:0] : rd_data[PW-1:0];

   assign gx_pos = {2'b00, top} + {1'b0, mid, 1'b0} + {2'b00, b_pix_ff};
   assign gx_neg = {2'b00, l0_ff} + {1'b0, l1_ff, 1'b0} + {2'b00, l2_ff};
   assign gy_pos = {2'b00, l2_ff} + {1'b0, c2_ff, 1'b0} + {2'b00, b_pix_ff};
   assign gy_neg = {2'b00, l0_ff} + {1'b0, c0_ff, 1'b0} + {2'b00, top};
   assign gx = $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
   assign gy = $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});

   always_comb begin
      q_push.push      = b_valid_ff && b_interior_ff;
      q_push.data.ax   = clamp_byte(gx);
      q_push.data.ay   = clamp_byte(gy);
      q_push.data.last = b_last_ff;
   end

endmodule

### rtl/sobel_queue.sv
module sobel_queue (
   input  logic                            clock,
   input  logic                            reset,
   input  sobel_pkg::grad_push_type        q_push,
   input  logic                            q_pop,
   output sobel_pkg::grad_head_type        q_head,
   output logic [sobel_pkg::QCOUNT_W-1:0]  q_count
);

   localparam int PTR_W = sobel_pkg::QPTR_W;
   localparam int CNT_W = sobel_pkg::QCOUNT_W;

   sobel_pkg::grad_type entry_ff [sobel_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign do_pop    = q_pop && (count_ff != '0);
   assign wr_ptr_in = q_push.push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
   assign rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (q_push.push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!q_push.push && do_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push.push) begin
         entry_ff[wr_ptr_ff] <= q_push.data;
      end
   end

   assign q_head.empty = (count_ff == '0);
   assign q_head.data  = entry_ff[rd_ptr_ff];
   assign q_count      = count_ff;

endmodule

### rtl/sobel_back.sv
module sobel_back (
   input  logic                            clock,
   input  logic                            reset,
   input  sobel_pkg::grad_head_type        q_head,
   output logic                            q_pop,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [sobel_pkg::PIX_W-1:0]     rsp_magnitude,
   output logic                            rsp_last_of_frame
);

   localparam int PW = sobel_pkg::PIX_W;
   localparam int SW = 2 * PW;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SQUARE = 5'b00010,
      ST_SUM    = 5'b00100,
      ST_ROOT   = 5'b01000,
      ST_HOLD   = 5'b10000
   } state_type;

   state_type      state_ff, state_in;
   logic [PW-1:0]  ax_ff, ay_ff;
   logic           last_ff;
   logic [SW-1:0]  sqx_ff, sqy_ff;
   logic [SW-1:0]  sum_ff, sum_in;
   logic [PW-1:0]  root_ff, root_in;
   logic [PW-1:0]  bit_ff, bit_in;
   logic           out_valid_ff, out_valid_in;
   logic [PW-1:0]  out_mag_ff;
   logic           out_last_ff;

   logic [SW:0]    sum_full;
   logic [PW-1:0]  trial;
   logic [SW-1:0]  trial_sq;
   logic           out_free;
   logic           out_load;

   assign sum_full = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign trial    = root_ff | bit_ff;
   assign trial_sq = trial * trial;
   assign out_free = !out_valid_ff || rsp_pop;
   assign out_load = (state_ff == ST_HOLD) && out_free;
   assign q_pop    = (state_ff == ST_IDLE) && !q_head.empty;

   always_comb begin
      state_in = state_ff;
      sum_in   = sum_ff;
      root_in  = root_ff;
      bit_in   = bit_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_head.empty) begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            // root of 2^16 or more saturates
            if (sum_full[SW]) begin
               root_in  = PW'(sobel_pkg::MAG_MAX);
               state_in = ST_HOLD;
            end else begin
               sum_in   = sum_full[SW-1:0];
               root_in  = '0;
               bit_in   = {1'b1, {(PW-1){1'b0}}};
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (trial_sq <= sum_ff) begin
               root_in = trial;
            end
            bit_in = bit_ff >> 1;
            if (bit_ff[0]) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
      if (out_load) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         ax_ff   <= q_head.data.ax;
         ay_ff   <= q_head.data.ay;
         last_ff <= q_head.data.last;
      end
      if (state_ff == ST_SQUARE) begin
         sqx_ff <= ax_ff * ax_ff;
         sqy_ff <= ay_ff * ay_ff;
      end
      sum_ff  <= sum_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
      if (out_load) begin
         out_mag_ff  <= root_ff;
         out_last_ff <= last_ff;
      end
   end

   assign rsp_empty         = !out_valid_ff;
   assign rsp_magnitude     = out_mag_ff;
   assign rsp_last_of_frame = out_last_ff;

endmodule

### rtl/sobel_edge_magnitude.sv
// Sobel edge magnitude over a raster stream of 8-bit intensities.
// Input queue side: drive req_intensity / req_start_of_frame and raise req_push;
// a pixel is taken on an edge with req_push high and req_full low. Border
// pixels (first two lines and columns) give no result.
// Result queue side: while rsp_empty is low, rsp_magnitude and rsp_last_of_frame
// hold the oldest result; rsp_pop takes it. A stalled receiver leaves the
// result in the output register; the gradient queue behind it keeps filling
// and req_full rises once it cannot take another interior pixel.
// Pixels enter at one per cycle while the gradient queue has room. Each
// interior pixel takes the back end through pop, square, sum, 8 root steps
// (one 8x8 multiply each) and output load, and skips the root steps when
// the sum of squares saturates; this sets the sustained rate for interior
// pixels. The back end works on one gradient at a time.
// CSR channel: csr_valid/csr_ready (always ready), csr_index 0 = line_width,
// 1 = frame_height; write only while the block is idle.
// Reset (synchronous, active high) empties all queues, zeroes the position
// counters and window, and sets both dimensions to 1024. The line store is
// not cleared and needs no clearing pass.
`include "sobel_edge_magnitude_macros.svh"

module sobel_edge_magnitude #(
   parameter int MAX_WIDTH  = sobel_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = sobel_pkg::DEF_MAX_HEIGHT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic [sobel_pkg::PIX_W-1:0]        req_intensity,
   input  logic                               req_start_of_frame,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic [sobel_pkg::PIX_W-1:0]        rsp_magnitude,
   output logic                               rsp_last_of_frame,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [sobel_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sobel_pkg::CFG_W-1:0]        csr_data
);

   localparam int CW  = $clog2(MAX_WIDTH + 1);
   localparam int RW  = $clog2(MAX_HEIGHT + 1);
   localparam int CFW = sobel_pkg::CFG_W;
   localparam int WCW = (CW > CFW) ? CW : CFW;
   localparam int WRW = (RW > CFW) ? RW : CFW;

   logic [CFW-1:0] line_width_ff, line_width_in;
   logic [CFW-1:0] frame_height_ff, frame_height_in;
   logic [WCW-1:0] width_wide;
   logic [WRW-1:0] height_wide;
   logic [CW-1:0]  width_eff;
   logic [RW-1:0]  height_eff;

   sobel_pkg::grad_push_type        q_push;
   sobel_pkg::grad_head_type        q_head;
   logic                            q_pop;
   logic [sobel_pkg::QCOUNT_W-1:0]  q_count;

   assign csr_ready = 1'b1;

   always_comb begin
      line_width_in   = line_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_valid) begin
         case (sobel_pkg::csr_index_type'(csr_index))
            sobel_pkg::CSR_LINE_WIDTH:   line_width_in   = csr_data;
            sobel_pkg::CSR_FRAME_HEIGHT: frame_height_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff   <= sobel_pkg::CFG_RESET;
         frame_height_ff <= sobel_pkg::CFG_RESET;
      end else begin
         line_width_ff   <= line_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   // dimensions in use, saturated to 3..MAX
   assign width_wide  = WCW'(line_width_ff);
   assign height_wide = WRW'(frame_height_ff);

   always_comb begin
      if (width_wide < WCW'(sobel_pkg::MIN_DIM)) begin
         width_eff = CW'(sobel_pkg::MIN_DIM);
      end else if (width_wide > WCW'(MAX_WIDTH)) begin
         width_eff = CW'(MAX_WIDTH);
      end else begin
         width_eff = width_wide[CW-1:0];
      end
      if (height_wide < WRW'(sobel_pkg::MIN_DIM)) begin
         height_eff = RW'(sobel_pkg::MIN_DIM);
      end else if (height_wide > WRW'(MAX_HEIGHT)) begin
         height_eff = RW'(MAX_HEIGHT);
      end else begin
         height_eff = height_wide[RW-1:0];
      end
   end

   sobel_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_intensity      (req_intensity),
      .req_start_of_frame (req_start_of_frame),
      .width_eff          (width_eff),
      .height_eff         (height_eff),
      .q_count            (q_count),
      .q_push             (q_push)
   );

   sobel_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_pop   (q_pop),
      .q_head  (q_head),
      .q_count (q_count)
   );

   sobel_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_head            (q_head),
      .q_pop             (q_pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_magnitude     (rsp_magnitude),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

   // the front's admission check must keep the gradient queue from overflowing
   `SOBEL_NEVER(a_queue_overflow, clock, reset,
      q_push.push && !q_pop && (q_count == sobel_pkg::QCOUNT_W'(sobel_pkg::QUEUE_DEPTH)))

   // back end only dequeues a present entry
   `SOBEL_NEVER(a_queue_underflow, clock, reset, q_pop && q_head.empty)

   // a full queue must hold off the input side
   `SOBEL_ASSERT(a_full_when_queue_full, clock, reset,
      (q_count == sobel_pkg::QCOUNT_W'(sobel_pkg::QUEUE_DEPTH)) |-> req_full)

endmodule
